@@ rtl/sfs_pkg.sv @@
// shared types and constants of the sprite frame sequencer
package sfs_pkg;

    localparam int MAX_FRAMES_DEF = 64;

    // request action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    // configuration register indexes
    localparam logic CFG_ANIM_MODE   = 1'b0;
    localparam logic CFG_FRAME_COUNT = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic tick_load;
        logic step_adv;
        logic walk_adv;
        logic psum_init;
        logic psum_acc;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic ge;
        logic steps_done;
        logic psum_last;
        logic div_last;
        logic stamp_new;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/sprite_frame_sequencer.sv @@
// top level of the sprite frame sequencer
// one request at a time; a new request is taken only once the last one has loaded its result: a step,
// a repeated stamp or action goes to the result, a table write rereads first, a tick walks its frames first
// a tick with time beyond 2n frame steps then sums the period over n frames, sets up the divider and
// runs 31 divide steps, then walks under 2n frames; a held result adds its wait
// synchronous active-low reset clears frame, direction, leftover, stamp and mode, sets frame count to 1, not table
module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_time_stamp,
    input  logic signed [31:0] i_elapsed,
    input  logic [5:0]         i_entry_index,
    input  logic [30:0]        i_entry_duration,
    input  logic [15:0]        i_entry_bitmap,
    input  logic [15:0]        i_entry_texcoords,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [5:0]         o_frame_index,
    output logic [15:0]        o_bitmap_id,
    output logic [15:0]        o_texcoords_id,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [6:0]         i_cfg_wdata
);
    import sfs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    sfs_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_time_stamp      (i_time_stamp),
        .i_elapsed         (i_elapsed),
        .i_entry_index     (i_entry_index),
        .i_entry_duration  (i_entry_duration),
        .i_entry_bitmap    (i_entry_bitmap),
        .i_entry_texcoords (i_entry_texcoords),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_frame_index     (o_frame_index),
        .o_bitmap_id       (o_bitmap_id),
        .o_texcoords_id    (o_texcoords_id)
    );

endmodule

@@ rtl/sfs_ctrl.sv @@
// control state machine of the sprite frame sequencer
module sfs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_action,
    input  sfs_pkg::t_sts i_sts,
    output sfs_pkg::t_cmd o_cmd
);
    import sfs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_WALK   = 7'b0000010,
        S_PSUM   = 7'b0000100,
        S_DINIT  = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_REREAD = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   w_cmd;

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_action)
                        ACT_WRITE: begin
                            w_cmd.wr_en = 1'b1;
                            n_state     = S_REREAD;
                        end
                        ACT_TICK: begin
                            if (i_sts.stamp_new) begin
                                w_cmd.tick_load = 1'b1;
                                n_state         = S_WALK;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        ACT_STEP: begin
                            w_cmd.step_adv = 1'b1;
                            n_state        = S_FIN;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_WALK: begin
                priority if (i_sts.ge && !i_sts.steps_done) begin
                    w_cmd.walk_adv = 1'b1;
                end else if (i_sts.ge) begin
                    // too much time left: reduce it modulo one full period
                    w_cmd.psum_init = 1'b1;
                    n_state         = S_PSUM;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_PSUM: begin
                w_cmd.psum_acc = 1'b1;
                if (i_sts.psum_last) begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                w_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_WALK;
                end
            end
            S_REREAD: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a pending one");

    a_step_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.walk_adv |-> !i_sts.steps_done)
        else $error("frame walk past its step limit");

    a_tick_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_action == ACT_TICK && i_sts.stamp_new)
        |=> r_state == S_WALK)
        else $error("new tick did not start a walk");

endmodule

@@ rtl/sfs_dp.sv @@
// datapath of the sprite frame sequencer: frame table, timing and divider
module sfs_dp #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfs_pkg::t_cmd      i_cmd,
    output sfs_pkg::t_sts      o_sts,
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [6:0]         i_cfg_wdata,
    input  logic signed [31:0] i_time_stamp,
    input  logic signed [31:0] i_elapsed,
    input  logic [5:0]         i_entry_index,
    input  logic [30:0]        i_entry_duration,
    input  logic [15:0]        i_entry_bitmap,
    input  logic [15:0]        i_entry_texcoords,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [5:0]         o_frame_index,
    output logic [15:0]        o_bitmap_id,
    output logic [15:0]        o_texcoords_id
);
    import sfs_pkg::*;

    localparam int CAP = (MAX_FRAMES < 64) ? MAX_FRAMES : 64;
    localparam int AW  = $clog2(CAP);
    localparam int NW  = AW + 1;
    localparam int SW  = AW + 2;
    localparam int PW  = 32 + AW;

    // frame table entry: duration, bitmap id, texcoord id
    logic [62:0] r_mem [CAP];
    logic [62:0] r_rd_q;

    logic              r_mode, n_mode;
    logic [6:0]        r_fcount, n_fcount;
    logic [AW-1:0]     r_cur, n_cur;
    logic              r_back, n_back;
    logic signed [31:0] r_left, n_left;
    logic [31:0]       r_last, n_last;
    logic [SW-1:0]     r_steps, n_steps;
    logic [NW-1:0]     r_pidx, n_pidx;
    logic [PW-1:0]     r_period, n_period;
    logic [PW-1:0]     r_divisor, n_divisor;
    logic [PW-1:0]     r_rem, n_rem;
    logic [30:0]       r_dvd, n_dvd;
    logic [4:0]        r_dcnt, n_dcnt;
    logic              r_out_valid;
    logic [5:0]        r_frame_index;
    logic [15:0]       r_bitmap_id;
    logic [15:0]       r_texcoords_id;

    logic [NW-1:0]     w_n;
    logic [30:0]       w_dur;
    logic              w_ge;
    logic [AW-1:0]     w_rd_addr;
    logic              w_wr_ok;

    function automatic logic [AW:0] f_past_end(input logic back, input logic mode,
                                               input logic [NW-1:0] n);
        logic [NW-1:0] last;
        last = n - 1'b1;
        if (mode) begin
            return {1'b1, last[AW-1:0]};
        end
        return {back, {AW{1'b0}}};
    endfunction

    function automatic logic [AW:0] f_fix(input logic [AW-1:0] cur, input logic back,
                                          input logic mode, input logic [NW-1:0] n);
        if ({1'b0, cur} >= n) begin
            return f_past_end(back, mode, n);
        end
        return {back, cur};
    endfunction

    function automatic logic [AW:0] f_adv(input logic [AW-1:0] cur, input logic back,
                                          input logic mode, input logic [NW-1:0] n);
        logic [NW-1:0] c1;
        c1 = {1'b0, cur} + 1'b1;
        if (back) begin
            if (cur == '0) begin
                return {1'b0, cur};
            end
            return {1'b1, cur - 1'b1};
        end
        if (c1 >= n) begin
            return f_past_end(back, mode, n);
        end
        return {1'b0, c1[AW-1:0]};
    endfunction

    // frames in use, clamped to the range 1 to the table size
    always_comb begin
        priority if (r_fcount == '0) begin
            w_n = NW'(1);
        end else if (r_fcount > 7'(CAP)) begin
            w_n = NW'(CAP);
        end else begin
            w_n = NW'(r_fcount);
        end
    end

    assign w_dur   = (r_rd_q[62:32] == '0) ? 31'd1 : r_rd_q[62:32];
    assign w_ge    = !r_left[31] && (r_left[30:0] >= w_dur);
    assign w_wr_ok = ({1'b0, i_entry_index} < 7'(CAP));

    always_comb begin
        logic [AW:0]        fx;
        logic [AW:0]        ad;
        logic signed [32:0] sum;
        logic [PW:0]        trial;
        n_mode    = r_mode;
        n_fcount  = r_fcount;
        n_cur     = r_cur;
        n_back    = r_back;
        n_left    = r_left;
        n_last    = r_last;
        n_steps   = r_steps;
        n_pidx    = r_pidx;
        n_period  = r_period;
        n_divisor = r_divisor;
        n_rem     = r_rem;
        n_dvd     = r_dvd;
        n_dcnt    = r_dcnt;
        fx        = f_fix(r_cur, r_back, r_mode, w_n);
        ad        = '0;
        sum       = {r_left[31], r_left} + {i_elapsed[31], i_elapsed};
        trial     = {r_rem, r_dvd[30]};

        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ANIM_MODE:   n_mode   = i_cfg_wdata[0];
                CFG_FRAME_COUNT: n_fcount = i_cfg_wdata;
                default:         n_mode   = r_mode;
            endcase
        end

        if (i_cmd.tick_load) begin
            n_last = i_time_stamp;
            // saturate leftover to the signed 32-bit range
            if (sum[32] != sum[31]) begin
                n_left = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                n_left = sum[31:0];
            end
            n_back  = fx[AW];
            n_cur   = fx[AW-1:0];
            n_steps = '0;
        end

        if (i_cmd.step_adv) begin
            ad     = f_adv(fx[AW-1:0], fx[AW], r_mode, w_n);
            n_back = ad[AW];
            n_cur  = ad[AW-1:0];
        end

        if (i_cmd.walk_adv) begin
            ad      = f_adv(r_cur, r_back, r_mode, w_n);
            n_back  = ad[AW];
            n_cur   = ad[AW-1:0];
            n_left  = r_left - $signed({1'b0, w_dur});
            n_steps = r_steps + 1'b1;
        end

        if (i_cmd.psum_init) begin
            n_pidx   = '0;
            n_period = '0;
        end

        if (i_cmd.psum_acc) begin
            n_pidx   = r_pidx + 1'b1;
            n_period = r_period + PW'(w_dur);
        end

        if (i_cmd.div_init) begin
            n_divisor = r_mode ? {r_period[PW-2:0], 1'b0} : r_period;
            n_rem     = '0;
            n_dvd     = r_left[30:0];
            n_dcnt    = '0;
        end

        // restoring division, one dividend bit per cycle
        if (i_cmd.div_step) begin
            if (trial >= {1'b0, r_divisor}) begin
                n_rem = PW'(trial - {1'b0, r_divisor});
            end else begin
                n_rem = trial[PW-1:0];
            end
            n_dvd  = {r_dvd[29:0], 1'b0};
            n_dcnt = r_dcnt + 1'b1;
            if (r_dcnt == 5'd30) begin
                n_left  = {1'b0, n_rem[30:0]};
                n_steps = '0;
            end
        end
    end

    assign w_rd_addr = (i_cmd.psum_init || i_cmd.psum_acc) ? n_pidx[AW-1:0] : n_cur;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_wr_ok) begin
            r_mem[i_entry_index[AW-1:0]] <= {i_entry_duration, i_entry_bitmap,
                                             i_entry_texcoords};
        end
        r_rd_q <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_fcount    <= 7'd1;
            r_cur       <= '0;
            r_back      <= 1'b0;
            r_left      <= '0;
            r_last      <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_fcount <= n_fcount;
            r_cur    <= n_cur;
            r_back   <= n_back;
            r_left   <= n_left;
            r_last   <= n_last;
            r_steps  <= n_steps;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx    <= n_pidx;
        r_period  <= n_period;
        r_divisor <= n_divisor;
        r_rem     <= n_rem;
        r_dvd     <= n_dvd;
        r_dcnt    <= n_dcnt;
        if (i_cmd.out_load) begin
            r_frame_index  <= 6'(r_cur);
            r_bitmap_id    <= r_rd_q[31:16];
            r_texcoords_id <= r_rd_q[15:0];
        end
    end

    assign o_sts.ge         = w_ge;
    assign o_sts.steps_done = (r_steps == {w_n, 1'b0});
    assign o_sts.psum_last  = (r_pidx == (w_n - 1'b1));
    assign o_sts.div_last   = (r_dcnt == 5'd30);
    assign o_sts.stamp_new  = (i_time_stamp != r_last);
    assign o_sts.out_free   = !r_out_valid || i_ready;

    assign o_valid        = r_out_valid;
    assign o_frame_index  = r_frame_index;
    assign o_bitmap_id    = r_bitmap_id;
    assign o_texcoords_id = r_texcoords_id;

    a_cur_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cur} < NW'(CAP))
        else $error("current frame outside the table");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_rem < r_divisor)
        else $error("division remainder not below divisor");

    a_left_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && r_dcnt == 5'd30) |=> !r_left[31])
        else $error("reduced leftover is negative");

endmodule
